>>> rtl/aps_pkg.sv
// Package for the Atkin prime sieve: request codes, memory operation codes,
// widths and the small modulo-12 helpers used by the candidate generator.
// No dependencies.
package aps_pkg;

    localparam int NUM_W       = 16;  // number, limit and count width
    localparam int ROOT_W      = 8;   // integer square root of a 16-bit limit
    localparam int MOD_W       = 4;   // residue modulo 12
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    localparam logic REQ_RUN   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [NUM_W-1:0] PRIME_TWO   = 16'd2;
    localparam logic [NUM_W-1:0] PRIME_THREE = 16'd3;
    localparam logic [ROOT_W-1:0] ELIM_FIRST = 8'd5;
    localparam logic [NUM_W-1:0] COUNT_MAX   = 16'hFFFF;

    localparam logic [MOD_W-1:0] RES_ONE    = 4'd1;
    localparam logic [MOD_W-1:0] RES_FIVE   = 4'd5;
    localparam logic [MOD_W-1:0] RES_SEVEN  = 4'd7;
    localparam logic [MOD_W-1:0] RES_ELEVEN = 4'd11;
    localparam logic [MOD_W-1:0] RES_LAST   = 4'd11;
    localparam logic [5:0]       MOD_BASE   = 6'd12;

    typedef enum logic [2:0] {
        OP_READ,
        OP_COUNT,
        OP_TOGGLE,
        OP_CLEAR,
        OP_SET
    } mem_op_t;

    // square of a residue, modulo 12
    function automatic logic [MOD_W-1:0] sq_mod12(input logic [MOD_W-1:0] r);
        logic [MOD_W-1:0] s;
        case (r)
            4'd0, 4'd6:                s = 4'd0;
            4'd1, 4'd5, 4'd7, 4'd11:   s = 4'd1;
            4'd2, 4'd4, 4'd8, 4'd10:   s = 4'd4;
            4'd3, 4'd9:                s = 4'd9;
            default:                   s = 4'd0;
        endcase
        return s;
    endfunction

    // reduce a value below 64 modulo 12
    function automatic logic [MOD_W-1:0] mod12(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        if (t >= 6'd48) t = t - 6'd48;
        if (t >= 6'd24) t = t - 6'd24;
        if (t >= 6'd12) t = t - 6'd12;
        return t[MOD_W-1:0];
    endfunction

endpackage

>>> rtl/aps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read and a write of the same entry in one cycle return the old contents.
// No dependencies.
module aps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/atkin_prime_sieve.sv
// Top level of the Atkin prime sieve: sequencer, candidate generator and
// read-modify-write pipeline around a one-bit-per-number memory.
// Depends on aps_pkg and aps_ram.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  cfg      | in        | cfg_wr_en (no wait)     | cfg_wr_data = upper_limit
//  s_       | in        | s_tvalid / s_tready     | s_tuser = req_type,
//           |           |                         | s_tdata = query_number
//  m_       | out       | m_tvalid / m_tready     | m_tdata = prime_count,
//           |           |                         | is_prime, out_of_range
//
// One word is worked on at a time; s_tready is high only while the sequencer
// is idle. A query makes at most one memory read.
// A run goes through 8 square-root steps, a clearing sweep of the whole
// memory, the setting of 2 and 3, a walk over root^2 (x, y) pairs that
// issues the toggles of each pair in turn, one read per n and one clear per
// multiple of the square of each marked n in the square elimination, and one
// read per number in the count.
// Reset clears the control state; the memory is not cleared by reset, and a
// query before the first run reports not prime. A stalled m_ side holds the
// result and keeps the sequencer waiting before it returns to idle.
module atkin_prime_sieve #(
    parameter int SIEVE_DEPTH = 65536
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: upper_limit
    input  logic                             cfg_wr_en,
    input  logic [aps_pkg::NUM_W-1:0]        cfg_wr_data,
    // requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [aps_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] query_number
    input  logic [0:0]                       s_tuser,   // [0] req_type
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [aps_pkg::M_TDATA_W-1:0]    m_tdata    // [15:0] prime_count,
                                                        // [16] is_prime,
                                                        // [17] out_of_range,
                                                        // [23:18] zero
);

    import aps_pkg::*;

    localparam int AW      = (SIEVE_DEPTH > 1) ? $clog2(SIEVE_DEPTH) : 1;
    localparam int XW      = (AW > NUM_W) ? AW : NUM_W;
    localparam int LIM_TOP = (SIEVE_DEPTH - 1 < 65535) ? SIEVE_DEPTH - 1 : 65535;
    localparam logic [NUM_W-1:0] LIM_TOP_V = NUM_W'(LIM_TOP);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(SIEVE_DEPTH - 1);
    localparam int PAD_W   = M_TDATA_W - NUM_W - 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CLR,
        ST_SET2,
        ST_SET3,
        ST_TOG,
        ST_ELIM_RD,
        ST_ELIM_WAIT,
        ST_ELIM_CLR,
        ST_CNT,
        ST_CNT_DRAIN,
        ST_Q_WAIT,
        ST_RESP
    } state_t;

    // map a number (always within the memory when it is used) to an address
    function automatic logic [AW-1:0] to_addr(input logic [NUM_W-1:0] v);
        logic [XW-1:0] e;
        e = XW'(v);
        return e[AW-1:0];
    endfunction

    // ---------------------------------------------------------------- registers
    state_t             state_reg, state_next;
    logic [NUM_W-1:0]   upper_limit_reg, upper_limit_next;
    logic [NUM_W-1:0]   last_count_reg, last_count_next;
    logic               ran_reg, ran_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [2:0]         bit_idx_reg, bit_idx_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [ROOT_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [MOD_W-1:0]   xm_reg, xm_next, ym_reg, ym_next;
    logic [NUM_W-1:0]   x2_reg, x2_next, y2_reg, y2_next;
    logic [17:0]        x3_reg, x3_next;
    logic               pair_done_reg, pair_done_next;
    logic [2:0]         mask_reg, mask_next;
    logic [NUM_W-1:0]   cand_reg [3];
    logic [NUM_W-1:0]   cand_next [3];
    logic [ROOT_W-1:0]  n_reg, n_next;
    logic [NUM_W-1:0]   sq_reg, sq_next, k_reg, k_next;
    logic [NUM_W-1:0]   i_reg, i_next;
    logic               res_prime_reg, res_prime_next;
    logic               res_oor_reg, res_oor_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    // memory pipeline, second stage
    logic               s2_valid_reg, s2_valid_next;
    mem_op_t            s2_op_reg, s2_op_next;
    logic [AW-1:0]      s2_addr_reg, s2_addr_next;
    logic               fwd_hit_reg, fwd_hit_next;
    logic               fwd_data_reg, fwd_data_next;

    // ---------------------------------------------------------------- datapath
    logic [NUM_W-1:0]   lim;
    logic               iss_valid;
    mem_op_t            iss_op;
    logic [AW-1:0]      iss_addr;
    logic               rd_bit, cur_bit, wr_en, wr_bit;

    // effective limit: never beyond the last memory entry
    assign lim = (upper_limit_reg > LIM_TOP_V) ? LIM_TOP_V : upper_limit_reg;

    // Stage two sees the read data; forward the write that overlapped the read.
    assign cur_bit = fwd_hit_reg ? fwd_data_reg : rd_bit;

    always_comb begin
        wr_en  = 1'b0;
        wr_bit = 1'b0;
        if (s2_valid_reg) begin
            case (s2_op_reg)
                OP_TOGGLE: begin
                    wr_en  = 1'b1;
                    wr_bit = ~cur_bit;
                end
                OP_CLEAR: begin
                    wr_en  = 1'b1;
                    wr_bit = 1'b0;
                end
                OP_SET: begin
                    wr_en  = 1'b1;
                    wr_bit = 1'b1;
                end
                default: begin
                    wr_en  = 1'b0;
                    wr_bit = 1'b0;
                end
            endcase
        end
    end

    aps_ram #(
        .WIDTH (1),
        .DEPTH (SIEVE_DEPTH)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s2_addr_reg),
        .wr_data (wr_bit),
        .rd_en   (iss_valid),
        .rd_addr (iss_addr),
        .rd_data (rd_bit)
    );

    // Candidate generator: evaluate the three quadratic forms for the current
    // (x, y) pair. Residues come from x mod 12 and y mod 12; squares are kept
    // incrementally so no multiplier sits in this path.
    logic [MOD_W-1:0] sqx, sqy, r1, r2, r3;
    logic [18:0]      n1, n2;
    logic [17:0]      n3;
    logic             c1, c2, c3;

    always_comb begin
        sqx = sq_mod12(xm_reg);
        sqy = sq_mod12(ym_reg);
        r1  = mod12({sqx, 2'b00} + 6'(sqy));
        r2  = mod12(6'({sqx, 1'b0}) + 6'(sqx) + 6'(sqy));
        r3  = mod12(6'({sqx, 1'b0}) + 6'(sqx) + MOD_BASE - 6'(sqy));
        n1  = 19'({x2_reg, 2'b00}) + 19'(y2_reg);
        n2  = 19'(x3_reg) + 19'(y2_reg);
        n3  = x3_reg - 18'(y2_reg);
        c1  = ((r1 == RES_ONE) || (r1 == RES_FIVE)) && (n1 <= 19'(lim));
        c2  = (r2 == RES_SEVEN) && (n2 <= 19'(lim));
        c3  = (x_reg > y_reg) && (r3 == RES_ELEVEN) && (n3 <= 18'(lim));
    end

    // pending toggles of the loaded pair, lowest first
    logic [2:0]       mask_low, mask_rest;
    logic [NUM_W-1:0] cand_sel;

    always_comb begin
        mask_low  = mask_reg & (~mask_reg + 3'd1);
        mask_rest = mask_reg & ~mask_low;
        if (mask_reg[0]) begin
            cand_sel = cand_reg[0];
        end else if (mask_reg[1]) begin
            cand_sel = cand_reg[1];
        end else begin
            cand_sel = cand_reg[2];
        end
    end

    // small products: square-root trial and elimination square
    logic [ROOT_W-1:0] trial;
    logic [NUM_W-1:0]  trial_sq, n_sq;
    logic [NUM_W:0]    k_sum;

    assign trial    = root_reg | (ROOT_W'(1) << bit_idx_reg);
    assign trial_sq = NUM_W'(trial) * NUM_W'(trial);
    assign n_sq     = NUM_W'(n_reg) * NUM_W'(n_reg);
    assign k_sum    = (NUM_W + 1)'(k_reg) + (NUM_W + 1)'(sq_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next       = state_reg;
        upper_limit_next = upper_limit_reg;
        last_count_next  = last_count_reg;
        ran_next         = ran_reg;
        root_next        = root_reg;
        bit_idx_next     = bit_idx_reg;
        clr_addr_next    = clr_addr_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        xm_next          = xm_reg;
        ym_next          = ym_reg;
        x2_next          = x2_reg;
        x3_next          = x3_reg;
        y2_next          = y2_reg;
        pair_done_next   = pair_done_reg;
        mask_next        = mask_reg;
        cand_next[0]     = cand_reg[0];
        cand_next[1]     = cand_reg[1];
        cand_next[2]     = cand_reg[2];
        n_next           = n_reg;
        sq_next          = sq_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        res_prime_next   = res_prime_reg;
        res_oor_next     = res_oor_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        iss_valid        = 1'b0;
        iss_op           = OP_READ;
        iss_addr         = '0;

        if (cfg_wr_en) begin
            upper_limit_next = cfg_wr_data;
        end

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // count marks leaving the pipeline; saturate
        if (s2_valid_reg && (s2_op_reg == OP_COUNT) && cur_bit
                && (last_count_reg != COUNT_MAX)) begin
            last_count_next = last_count_reg + 16'd1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == REQ_RUN) begin
                        last_count_next = '0;
                        root_next       = '0;
                        bit_idx_next    = 3'(ROOT_W - 1);
                        state_next      = ST_SQRT;
                    end else if (s_tdata > lim) begin
                        res_oor_next   = 1'b1;
                        res_prime_next = 1'b0;
                        state_next     = ST_RESP;
                    end else if (!ran_reg) begin
                        res_oor_next   = 1'b0;
                        res_prime_next = 1'b0;
                        state_next     = ST_RESP;
                    end else begin
                        iss_valid  = 1'b1;
                        iss_op     = OP_READ;
                        iss_addr   = to_addr(s_tdata);
                        state_next = ST_Q_WAIT;
                    end
                end
            end
            ST_Q_WAIT: begin
                res_prime_next = cur_bit;
                res_oor_next   = 1'b0;
                state_next     = ST_RESP;
            end
            ST_SQRT: begin
                // one root bit per cycle, most significant first
                if (trial_sq <= lim) begin
                    root_next = trial;
                end
                if (bit_idx_reg == 3'd0) begin
                    clr_addr_next = '0;
                    state_next    = ST_CLR;
                end else begin
                    bit_idx_next = bit_idx_reg - 3'd1;
                end
            end
            ST_CLR: begin
                iss_valid = 1'b1;
                iss_op    = OP_CLEAR;
                iss_addr  = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_SET2;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_SET2: begin
                if (lim >= PRIME_TWO) begin
                    iss_valid = 1'b1;
                    iss_op    = OP_SET;
                    iss_addr  = to_addr(PRIME_TWO);
                end
                state_next = ST_SET3;
            end
            ST_SET3: begin
                if (lim >= PRIME_THREE) begin
                    iss_valid = 1'b1;
                    iss_op    = OP_SET;
                    iss_addr  = to_addr(PRIME_THREE);
                end
                // start the pair walk at x = y = 1
                x_next         = 8'd1;
                y_next         = 8'd1;
                xm_next        = 4'd1;
                ym_next        = 4'd1;
                x2_next        = 16'd1;
                x3_next        = 18'd3;
                y2_next        = 16'd1;
                mask_next      = '0;
                pair_done_next = 1'b0;
                if (root_reg == '0) begin
                    i_next     = '0;
                    state_next = ST_CNT;
                end else begin
                    state_next = ST_TOG;
                end
            end
            ST_TOG: begin
                if (mask_reg != '0) begin
                    iss_valid = 1'b1;
                    iss_op    = OP_TOGGLE;
                    iss_addr  = to_addr(cand_sel);
                end
                mask_next = mask_rest;
                if (mask_rest == '0) begin
                    if (!pair_done_reg) begin
                        // load the current pair and advance
                        mask_next    = {c3, c2, c1};
                        cand_next[0] = n1[NUM_W-1:0];
                        cand_next[1] = n2[NUM_W-1:0];
                        cand_next[2] = n3[NUM_W-1:0];
                        if (y_reg == root_reg) begin
                            y_next         = 8'd1;
                            ym_next        = 4'd1;
                            y2_next        = 16'd1;
                            x_next         = x_reg + 8'd1;
                            xm_next        = (xm_reg == RES_LAST) ? '0 : xm_reg + 4'd1;
                            x2_next        = x2_reg + NUM_W'({x_reg, 1'b1});
                            x3_next        = x3_reg + 18'({x_reg, 1'b1})
                                             + 18'({x_reg, 2'b10});
                            pair_done_next = (x_reg == root_reg);
                        end else begin
                            y_next  = y_reg + 8'd1;
                            ym_next = (ym_reg == RES_LAST) ? '0 : ym_reg + 4'd1;
                            y2_next = y2_reg + NUM_W'({y_reg, 1'b1});
                        end
                    end else if (root_reg >= ELIM_FIRST) begin
                        n_next     = ELIM_FIRST;
                        state_next = ST_ELIM_RD;
                    end else begin
                        i_next     = '0;
                        state_next = ST_CNT;
                    end
                end
            end
            ST_ELIM_RD: begin
                iss_valid  = 1'b1;
                iss_op     = OP_READ;
                iss_addr   = to_addr(NUM_W'(n_reg));
                state_next = ST_ELIM_WAIT;
            end
            ST_ELIM_WAIT: begin
                if (cur_bit) begin
                    sq_next    = n_sq;
                    k_next     = n_sq;
                    state_next = ST_ELIM_CLR;
                end else if (n_reg == root_reg) begin
                    i_next     = '0;
                    state_next = ST_CNT;
                end else begin
                    n_next     = n_reg + 8'd1;
                    state_next = ST_ELIM_RD;
                end
            end
            ST_ELIM_CLR: begin
                iss_valid = 1'b1;
                iss_op    = OP_CLEAR;
                iss_addr  = to_addr(k_reg);
                if (k_sum <= (NUM_W + 1)'(lim)) begin
                    k_next = k_sum[NUM_W-1:0];
                end else if (n_reg == root_reg) begin
                    i_next     = '0;
                    state_next = ST_CNT;
                end else begin
                    n_next     = n_reg + 8'd1;
                    state_next = ST_ELIM_RD;
                end
            end
            ST_CNT: begin
                iss_valid = 1'b1;
                iss_op    = OP_COUNT;
                iss_addr  = to_addr(i_reg);
                if (i_reg == lim) begin
                    state_next = ST_CNT_DRAIN;
                end else begin
                    i_next = i_reg + 16'd1;
                end
            end
            ST_CNT_DRAIN: begin
                // last count read retires this cycle
                res_prime_next = 1'b0;
                res_oor_next   = 1'b0;
                ran_next       = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {PAD_W'(0), res_oor_reg, res_prime_reg,
                                     last_count_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // advance the memory pipeline; remember a write that hits this read
        s2_valid_next = iss_valid;
        s2_op_next    = iss_op;
        s2_addr_next  = iss_addr;
        fwd_hit_next  = wr_en && (s2_addr_reg == iss_addr);
        fwd_data_next = wr_bit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            upper_limit_reg <= 16'hFFFF;
            last_count_reg  <= '0;
            ran_reg         <= 1'b0;
            mask_reg        <= '0;
            pair_done_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            upper_limit_reg <= upper_limit_next;
            last_count_reg  <= last_count_next;
            ran_reg         <= ran_next;
            mask_reg        <= mask_next;
            pair_done_reg   <= pair_done_next;
            m_tvalid_reg    <= m_tvalid_next;
            s2_valid_reg    <= s2_valid_next;
            fwd_hit_reg     <= fwd_hit_next;
        end
        root_reg      <= root_next;
        bit_idx_reg   <= bit_idx_next;
        clr_addr_reg  <= clr_addr_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        xm_reg        <= xm_next;
        ym_reg        <= ym_next;
        x2_reg        <= x2_next;
        x3_reg        <= x3_next;
        y2_reg        <= y2_next;
        cand_reg[0]   <= cand_next[0];
        cand_reg[1]   <= cand_next[1];
        cand_reg[2]   <= cand_next[2];
        n_reg         <= n_next;
        sq_reg        <= sq_next;
        k_reg         <= k_next;
        i_reg         <= i_next;
        res_prime_reg <= res_prime_next;
        res_oor_reg   <= res_oor_next;
        m_tdata_reg   <= m_tdata_next;
        s2_op_reg     <= s2_op_next;
        s2_addr_reg   <= s2_addr_next;
        fwd_data_reg  <= fwd_data_next;
    end

    // ---------------------------------------------------------------- checks
    // the pipeline is empty whenever a new word may be taken
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !s2_valid_reg)
        else $error("memory operation pending while idle");

    // pending toggles never outlive the pair walk
    a_mask_in_tog: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_TOG) |-> (mask_reg == '0))
        else $error("toggle pending outside the pair walk");

    // square elimination stays inside the limit and starts at the square
    a_elim_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ELIM_CLR) |-> ((k_reg <= lim) && (k_reg >= sq_reg)))
        else $error("elimination address out of bounds");

    // one word in flight at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

endmodule
